@@ design/kmed_pkg.sv @@
`timescale 1ns / 1ps

package kmed_pkg;

    localparam int COORD_W = 16;
    localparam int SUM_W   = 40;                  // squared distances and member sums
    localparam int FRAC_W  = 16;                  // sq << 16 gives 8 fraction bits of root
    localparam int RAD_W   = SUM_W + FRAC_W;
    localparam int ROOT_W  = RAD_W / 2;

    localparam logic [1:0] FUNC_LOAD     = 2'd0;
    localparam logic [1:0] FUNC_START    = 2'd1;
    localparam logic [1:0] FUNC_READ_ASG = 2'd2;
    localparam logic [1:0] FUNC_READ_MED = 2'd3;

    localparam logic [1:0] REG_POINTS   = 2'd0;
    localparam logic [1:0] REG_DIMS     = 2'd1;
    localparam logic [1:0] REG_CLUSTERS = 2'd2;
    localparam logic [1:0] REG_ITERS    = 2'd3;

    localparam logic [10:0] RST_POINTS   = 11'd1024;
    localparam logic [3:0]  RST_DIMS     = 4'd2;
    localparam logic [4:0]  RST_CLUSTERS = 5'd4;
    localparam logic [7:0]  RST_ITERS    = 8'd20;

    typedef struct packed {
        logic [1:0]         func;
        logic [9:0]         point_index;
        logic [2:0]         dim_index;
        logic signed [15:0] coord_in;
    } req_t;

    typedef struct packed {
        logic [3:0]         cluster_out;
        logic signed [15:0] coord_out;
        logic               index_error;
    } rsp_t;

endpackage

@@ design/k_medoids_clustering.sv @@
`timescale 1ns / 1ps

// Channel  Signals                               Direction
// -------  ------------------------------------  ------------------
// req      req_valid, req_ready, req             request in
// rsp      rsp_valid, rsp_ready, rsp             one result out per request
// cfg      cfg_valid, cfg_ready, cfg_index/data  register write in
//
// Load and read requests pass through the memory read stage s1 to the result register;
// they are taken back to back unless the result side stalls.
// A start request holds the block for the whole run: per iteration, n*k distance passes
// on the dual-read point memory, then for each same-cluster pair a distance pass, a
// square root and a member-sum read-modify-write, then medoid choice over all n
// points.
// After reset a clearing pass over all MAX_POINTS entries zeroes the assignment memory; no
// request is taken during it, configuration writes are.
module k_medoids_clustering #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_DIMS     = 8,
    parameter int MAX_CLUSTERS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  kmed_pkg::req_t      req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output kmed_pkg::rsp_t      rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [10:0]         cfg_data
);

    localparam int PW = $clog2(MAX_POINTS);
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int KW = $clog2(MAX_CLUSTERS);
    localparam int PT_DEPTH = MAX_POINTS * (2 ** DW);
    localparam int SUM_W = kmed_pkg::SUM_W;
    localparam int RAD_W = kmed_pkg::RAD_W;
    localparam int ROOT_W = kmed_pkg::ROOT_W;
    localparam int CW = $clog2(ROOT_W);

    localparam logic [4:0] ST_CLR    = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_SEED   = 5'd2;
    localparam logic [4:0] ST_A_PT   = 5'd3;
    localparam logic [4:0] ST_D_RUN  = 5'd4;
    localparam logic [4:0] ST_A_CMP  = 5'd5;
    localparam logic [4:0] ST_A_WR   = 5'd6;
    localparam logic [4:0] ST_B_INIT = 5'd7;
    localparam logic [4:0] ST_B_ROW  = 5'd8;
    localparam logic [4:0] ST_B_ROW2 = 5'd9;
    localparam logic [4:0] ST_B_COL  = 5'd10;
    localparam logic [4:0] ST_B_CMP  = 5'd11;
    localparam logic [4:0] ST_B_SQ   = 5'd12;
    localparam logic [4:0] ST_B_SQRT = 5'd13;
    localparam logic [4:0] ST_B_ADD1 = 5'd14;
    localparam logic [4:0] ST_B_ADD2 = 5'd15;
    localparam logic [4:0] ST_C_RD   = 5'd16;
    localparam logic [4:0] ST_C_CMP  = 5'd17;
    localparam logic [4:0] ST_UPD    = 5'd18;
    localparam logic [4:0] ST_DONE   = 5'd19;

    // configuration
    logic [10:0] cfg_points_reg;
    logic [3:0]  cfg_dims_reg;
    logic [4:0]  cfg_clusters_reg;
    logic [7:0]  cfg_iters_reg;

    logic [PW:0] n_eff;
    logic [DW:0] d_eff;
    logic [KW:0] k_eff;
    logic [31:0] k_raw;

    // control
    logic [4:0]  state_reg;
    logic [4:0]  ret_reg;
    logic [PW:0] i_reg;
    logic [PW:0] j_reg;
    logic [KW:0] c_reg;
    logic [7:0]  it_reg;

    // distance engine
    logic [PW-1:0]    pa_reg;
    logic [PW-1:0]    pb_reg;
    logic [DW:0]      dj_reg;
    logic             p1_v_reg, p1_last_reg;
    logic             p2_v_reg, p2_last_reg;
    logic             p3_v_reg, p3_last_reg;
    logic [15:0]      ad_reg;
    logic [31:0]      sq_reg;
    logic [SUM_W-1:0] acc_reg;
    logic             issue;
    logic signed [16:0] diff;
    logic signed [16:0] diff_abs;

    // assignment search
    logic [SUM_W-1:0] bd_reg;
    logic [KW-1:0]    best_reg;

    // member sums and square root
    logic [KW-1:0]    ai_reg;
    logic [SUM_W-1:0] acci_reg;
    logic [RAD_W-1:0] sx_reg;
    logic [RAD_W-1:0] sr_reg;
    logic [RAD_W-1:0] sb_reg;
    logic [CW-1:0]    scnt_reg;
    logic [RAD_W:0]   strial;
    logic [SUM_W-1:0] dd;

    // medoids
    logic [PW-1:0]    med_reg  [MAX_CLUSTERS];
    logic [PW-1:0]    nxt_reg  [MAX_CLUSTERS];
    logic [SUM_W-1:0] best_sum_reg [MAX_CLUSTERS];
    logic             changed;

    // response path
    logic        s1_valid_reg;
    logic [1:0]  s1_func_reg;
    logic        s1_err_reg;
    logic        s1_adv;
    logic        rsp_valid_reg;
    kmed_pkg::rsp_t rsp_reg;
    logic        req_fire;
    logic        req_err;

    // memories
    logic [15:0]      pt_mem [PT_DEPTH];
    logic             pt_we, pt_rd_en;
    logic [PW+DW-1:0] pt_waddr, pt_addr_a, pt_addr_b;
    logic [15:0]      pt_rd_a, pt_rd_b;

    logic [KW-1:0]    as_mem [MAX_POINTS];
    logic             as_we, as_rd_en;
    logic [PW-1:0]    as_waddr, as_raddr;
    logic [KW-1:0]    as_wdata, as_rd;

    logic [SUM_W-1:0] ms_mem [MAX_POINTS];
    logic             ms_we, ms_rd_en;
    logic [PW-1:0]    ms_waddr, ms_raddr;
    logic [SUM_W-1:0] ms_wdata, ms_rd;

    // effective sizes
    always_comb
    begin
        if (cfg_points_reg == '0)
            n_eff = (PW+1)'(1);
        else if (32'(cfg_points_reg) > MAX_POINTS)
            n_eff = (PW+1)'(MAX_POINTS);
        else
            n_eff = (PW+1)'(cfg_points_reg);

        if (cfg_dims_reg == '0)
            d_eff = (DW+1)'(1);
        else if (32'(cfg_dims_reg) > MAX_DIMS)
            d_eff = (DW+1)'(MAX_DIMS);
        else
            d_eff = (DW+1)'(cfg_dims_reg);

        if (cfg_clusters_reg == '0)
            k_raw = 32'd1;
        else if (32'(cfg_clusters_reg) > MAX_CLUSTERS)
            k_raw = 32'(MAX_CLUSTERS);
        else
            k_raw = 32'(cfg_clusters_reg);
        if (k_raw > 32'(n_eff))
            k_raw = 32'(n_eff);
        k_eff = (KW+1)'(k_raw);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_points_reg   <= kmed_pkg::RST_POINTS;
            cfg_dims_reg     <= kmed_pkg::RST_DIMS;
            cfg_clusters_reg <= kmed_pkg::RST_CLUSTERS;
            cfg_iters_reg    <= kmed_pkg::RST_ITERS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                kmed_pkg::REG_POINTS:   cfg_points_reg   <= cfg_data;
                kmed_pkg::REG_DIMS:     cfg_dims_reg     <= cfg_data[3:0];
                kmed_pkg::REG_CLUSTERS: cfg_clusters_reg <= cfg_data[4:0];
                kmed_pkg::REG_ITERS:    cfg_iters_reg    <= cfg_data[7:0];
            endcase
        end
    end

    // handshake and request checks
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == ST_IDLE) && (!s1_valid_reg || s1_adv);
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        unique case (req.func)
            kmed_pkg::FUNC_LOAD:
                req_err = (req.point_index >= n_eff) || (req.dim_index >= d_eff);
            kmed_pkg::FUNC_START:
                req_err = 1'b0;
            kmed_pkg::FUNC_READ_ASG:
                req_err = (req.point_index >= n_eff);
            kmed_pkg::FUNC_READ_MED:
                req_err = (req.point_index >= k_eff) || (req.dim_index >= d_eff);
        endcase
    end

    // distance datapath
    assign issue    = (state_reg == ST_D_RUN) && (dj_reg < d_eff);
    assign diff     = $signed({pt_rd_a[15], pt_rd_a}) - $signed({pt_rd_b[15], pt_rd_b});
    assign diff_abs = diff[16] ? -diff : diff;

    // square root step
    assign strial = {1'b0, sr_reg} + {1'b0, sb_reg};
    assign dd     = SUM_W'(sr_reg);

    always_comb
    begin
        changed = 1'b0;
        for (int c = 0; c < MAX_CLUSTERS; c++)
            if (nxt_reg[c] != med_reg[c])
                changed = 1'b1;
    end

    // memory access control
    always_comb
    begin
        pt_we     = 1'b0;
        pt_waddr  = {PW'(req.point_index), DW'(req.dim_index)};
        pt_rd_en  = 1'b0;
        pt_addr_a = {pa_reg, dj_reg[DW-1:0]};
        pt_addr_b = {pb_reg, dj_reg[DW-1:0]};
        as_we     = 1'b0;
        as_waddr  = PW'(i_reg);
        as_wdata  = best_reg;
        as_rd_en  = 1'b0;
        as_raddr  = PW'(i_reg);
        ms_we     = 1'b0;
        ms_waddr  = PW'(i_reg);
        ms_wdata  = '0;
        ms_rd_en  = 1'b0;
        ms_raddr  = PW'(i_reg);
        unique case (state_reg)
            ST_CLR:
            begin
                as_we    = 1'b1;
                as_wdata = '0;
            end
            ST_IDLE:
            begin
                if (req_fire && !req_err)
                begin
                    pt_we    = (req.func == kmed_pkg::FUNC_LOAD);
                    as_rd_en = (req.func == kmed_pkg::FUNC_READ_ASG);
                    as_raddr = PW'(req.point_index);
                    pt_rd_en = (req.func == kmed_pkg::FUNC_READ_MED);
                    pt_addr_a = {med_reg[KW'(req.point_index)], DW'(req.dim_index)};
                end
            end
            ST_D_RUN:
                pt_rd_en = issue;
            ST_A_WR:
            begin
                as_we = 1'b1;
                ms_we = 1'b1;
            end
            ST_B_ROW:
            begin
                as_rd_en = (i_reg < n_eff);
                ms_rd_en = (i_reg < n_eff);
            end
            ST_B_COL:
            begin
                as_rd_en = (j_reg < n_eff);
                as_raddr = PW'(j_reg);
                ms_we    = !(j_reg < n_eff);
                ms_wdata = acci_reg;
            end
            ST_B_ADD1:
            begin
                ms_rd_en = 1'b1;
                ms_raddr = PW'(j_reg);
            end
            ST_B_ADD2:
            begin
                ms_we    = 1'b1;
                ms_waddr = PW'(j_reg);
                ms_wdata = ms_rd + dd;
            end
            ST_C_RD:
            begin
                as_rd_en = (i_reg < n_eff);
                ms_rd_en = (i_reg < n_eff);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= req.coord_in;
        if (pt_rd_en)
        begin
            pt_rd_a <= pt_mem[pt_addr_a];
            pt_rd_b <= pt_mem[pt_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (as_we)
            as_mem[as_waddr] <= as_wdata;
        if (as_rd_en)
            as_rd <= as_mem[as_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ms_we)
            ms_mem[ms_waddr] <= ms_wdata;
        if (ms_rd_en)
            ms_rd <= ms_mem[ms_raddr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            ret_reg     <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            c_reg       <= '0;
            it_reg      <= '0;
            pa_reg      <= '0;
            pb_reg      <= '0;
            dj_reg      <= '0;
            p1_v_reg    <= 1'b0;
            p1_last_reg <= 1'b0;
            p2_v_reg    <= 1'b0;
            p2_last_reg <= 1'b0;
            p3_v_reg    <= 1'b0;
            p3_last_reg <= 1'b0;
            ad_reg      <= '0;
            sq_reg      <= '0;
            acc_reg     <= '0;
            bd_reg      <= '0;
            best_reg    <= '0;
            ai_reg      <= '0;
            acci_reg    <= '0;
            sx_reg      <= '0;
            sr_reg      <= '0;
            sb_reg      <= '0;
            scnt_reg    <= '0;
            for (int c = 0; c < MAX_CLUSTERS; c++)
            begin
                med_reg[c]      <= PW'(c);
                nxt_reg[c]      <= PW'(c);
                best_sum_reg[c] <= '1;
            end
        end
        else
        begin
            // distance pipeline: read, absolute difference, square, accumulate
            p1_v_reg    <= issue;
            p1_last_reg <= issue && ((dj_reg + 1'b1) == d_eff);
            p2_v_reg    <= p1_v_reg;
            p2_last_reg <= p1_last_reg;
            p3_v_reg    <= p2_v_reg;
            p3_last_reg <= p2_last_reg;
            ad_reg      <= 16'(diff_abs);
            sq_reg      <= ad_reg * ad_reg;
            if (issue)
                dj_reg <= dj_reg + 1'b1;
            if (p3_v_reg)
                acc_reg <= acc_reg + SUM_W'(sq_reg);

            unique case (state_reg)
                ST_CLR:
                begin
                    if (i_reg == (PW+1)'(MAX_POINTS - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (req_fire && req.func == kmed_pkg::FUNC_START)
                        state_reg <= ST_SEED;
                end
                ST_SEED:
                begin
                    for (int c = 0; c < MAX_CLUSTERS; c++)
                        if (c < int'(k_eff))
                            med_reg[c] <= PW'(c);
                    i_reg  <= '0;
                    it_reg <= '0;
                    state_reg <= (cfg_iters_reg == '0) ? ST_DONE : ST_A_PT;
                end
                ST_A_PT:
                begin
                    c_reg     <= '0;
                    pa_reg    <= PW'(i_reg);
                    pb_reg    <= med_reg[0];
                    dj_reg    <= '0;
                    acc_reg   <= '0;
                    ret_reg   <= ST_A_CMP;
                    state_reg <= ST_D_RUN;
                end
                ST_D_RUN:
                begin
                    if (p3_v_reg && p3_last_reg)
                        state_reg <= ret_reg;
                end
                ST_A_CMP:
                begin
                    // strict compare keeps the lowest cluster on a tie
                    if (c_reg == '0 || acc_reg < bd_reg)
                    begin
                        bd_reg   <= acc_reg;
                        best_reg <= KW'(c_reg);
                    end
                    if ((c_reg + 1'b1) < k_eff)
                    begin
                        c_reg     <= c_reg + 1'b1;
                        pb_reg    <= med_reg[KW'(c_reg + 1'b1)];
                        dj_reg    <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_D_RUN;
                    end
                    else
                        state_reg <= ST_A_WR;
                end
                ST_A_WR:
                begin
                    if ((i_reg + 1'b1) < n_eff)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_A_PT;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_B_INIT;
                    end
                end
                ST_B_INIT:
                begin
                    for (int c = 0; c < MAX_CLUSTERS; c++)
                    begin
                        best_sum_reg[c] <= '1;
                        nxt_reg[c]      <= med_reg[c];
                    end
                    state_reg <= ST_B_ROW;
                end
                ST_B_ROW:
                begin
                    if (i_reg < n_eff)
                        state_reg <= ST_B_ROW2;
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_C_RD;
                    end
                end
                ST_B_ROW2:
                begin
                    ai_reg    <= as_rd;
                    acci_reg  <= ms_rd;
                    j_reg     <= i_reg + 1'b1;
                    state_reg <= ST_B_COL;
                end
                ST_B_COL:
                begin
                    if (j_reg < n_eff)
                        state_reg <= ST_B_CMP;
                    else
                    begin
                        // row sum written back above
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_B_ROW;
                    end
                end
                ST_B_CMP:
                begin
                    if (as_rd == ai_reg)
                    begin
                        pa_reg    <= PW'(i_reg);
                        pb_reg    <= PW'(j_reg);
                        dj_reg    <= '0;
                        acc_reg   <= '0;
                        ret_reg   <= ST_B_SQ;
                        state_reg <= ST_D_RUN;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_B_COL;
                    end
                end
                ST_B_SQ:
                begin
                    sx_reg    <= {acc_reg, {kmed_pkg::FRAC_W{1'b0}}};
                    sr_reg    <= '0;
                    sb_reg    <= {2'b01, {(RAD_W - 2){1'b0}}};
                    scnt_reg  <= CW'(ROOT_W - 1);
                    state_reg <= ST_B_SQRT;
                end
                ST_B_SQRT:
                begin
                    // one root bit per cycle
                    if ({1'b0, sx_reg} >= strial)
                    begin
                        sx_reg <= sx_reg - RAD_W'(strial);
                        sr_reg <= (sr_reg >> 1) + sb_reg;
                    end
                    else
                        sr_reg <= sr_reg >> 1;
                    sb_reg <= sb_reg >> 2;
                    if (scnt_reg == '0)
                        state_reg <= ST_B_ADD1;
                    else
                        scnt_reg <= scnt_reg - 1'b1;
                end
                ST_B_ADD1:
                    state_reg <= ST_B_ADD2;
                ST_B_ADD2:
                begin
                    acci_reg  <= acci_reg + dd;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= ST_B_COL;
                end
                ST_C_RD:
                begin
                    state_reg <= (i_reg < n_eff) ? ST_C_CMP : ST_UPD;
                end
                ST_C_CMP:
                begin
                    if (ms_rd < best_sum_reg[as_rd])
                    begin
                        best_sum_reg[as_rd] <= ms_rd;
                        nxt_reg[as_rd]      <= PW'(i_reg);
                    end
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_C_RD;
                end
                ST_UPD:
                begin
                    for (int c = 0; c < MAX_CLUSTERS; c++)
                        med_reg[c] <= nxt_reg[c];
                    it_reg <= it_reg + 1'b1;
                    i_reg  <= '0;
                    // stop early once the medoids settle
                    if (!changed || (it_reg + 1'b1) == cfg_iters_reg)
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_A_PT;
                end
                ST_DONE:
                begin
                    if (!s1_valid_reg || s1_adv)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // result stage: memory data lands alongside s1, then the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_func_reg   <= kmed_pkg::FUNC_LOAD;
            s1_err_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (req_fire && req.func != kmed_pkg::FUNC_START)
            begin
                s1_valid_reg <= 1'b1;
                s1_func_reg  <= req.func;
                s1_err_reg   <= req_err;
            end
            else if (state_reg == ST_DONE && (!s1_valid_reg || s1_adv))
            begin
                s1_valid_reg <= 1'b1;
                s1_func_reg  <= kmed_pkg::FUNC_START;
                s1_err_reg   <= 1'b0;
            end
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                rsp_valid_reg           <= 1'b1;
                rsp_reg.index_error     <= s1_err_reg;
                rsp_reg.cluster_out     <= (s1_func_reg == kmed_pkg::FUNC_READ_ASG && !s1_err_reg)
                                           ? 4'(as_rd) : 4'd0;
                rsp_reg.coord_out       <= (s1_func_reg == kmed_pkg::FUNC_READ_MED && !s1_err_reg)
                                           ? pt_rd_a : 16'sd0;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ tb/k_medoids_clustering_tb.sv @@
`timescale 1ns / 1ps

module k_medoids_clustering_tb;

    localparam int  NPTS      = 1024;
    localparam int  NDIM      = 8;
    localparam int  NCLU      = 16;
    localparam int  RUN_BUDGET = 40000;
    localparam int  CYCLE_CAP = 6000000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    kmed_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    kmed_pkg::rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [10:0] cfg_data;

    k_medoids_clustering u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the clustering engine
    logic [15:0]     pts [0:NPTS*NDIM-1];
    bit              pts_set [0:NPTS*NDIM-1];
    logic [3:0]      asg [0:NPTS-1];
    int              med [0:NCLU-1];
    int              nxt [0:NCLU-1];
    longint unsigned bsum [0:NCLU-1];
    longint unsigned msum [0:NPTS-1];
    int              n_pts, n_dims, n_clu, n_iter;

    kmed_pkg::req_t pending_reqs[$];
    kmed_pkg::rsp_t due_rsps[$];

    int send_idle, recv_idle;
    int hold_cnt, hold_asked, hold_taken;
    int mismatches, checked, cycles, items, runs;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int eff_n();
        return (n_pts < 1) ? 1 : (n_pts > NPTS) ? NPTS : n_pts;
    endfunction

    function automatic int eff_d();
        return (n_dims < 1) ? 1 : (n_dims > NDIM) ? NDIM : n_dims;
    endfunction

    function automatic int eff_k();
        int k;
        k = (n_clu < 1) ? 1 : (n_clu > NCLU) ? NCLU : n_clu;
        return (k > eff_n()) ? eff_n() : k;
    endfunction

    function automatic longint unsigned sq_gap(int a, int b, int dims);
        longint unsigned s;
        longint df;
        s = 0;
        for (int j = 0; j < dims; j++)
        begin
            df = longint'($signed(pts[a*NDIM+j])) - longint'($signed(pts[b*NDIM+j]));
            if (df < 0)
                df = -df;
            s += longint'(df) * longint'(df);
        end
        return s;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic cluster_run();
        int n, d, k, best;
        longint unsigned bd, sd, dd;
        bit moved;
        n = eff_n();
        d = eff_d();
        k = eff_k();
        for (int c = 0; c < k; c++)
            med[c] = c;
        for (int it = 0; it < n_iter; it++)
        begin
            for (int i = 0; i < n; i++)
            begin
                best = 0;
                bd = sq_gap(i, med[0], d);
                for (int c = 1; c < k; c++)
                begin
                    sd = sq_gap(i, med[c], d);
                    if (sd < bd)
                    begin
                        bd = sd;
                        best = c;
                    end
                end
                asg[i] = best[3:0];
            end
            for (int c = 0; c < k; c++)
            begin
                bsum[c] = 64'hFF_FFFF_FFFF;
                nxt[c] = med[c];
            end
            for (int i = 0; i < n; i++)
                msum[i] = 0;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (asg[i] == asg[j])
                    begin
                        dd = int_root(sq_gap(i, j, d) << 16);
                        msum[i] += dd;
                        msum[j] += dd;
                    end
            for (int i = 0; i < n; i++)
                if (msum[i] < bsum[asg[i]])
                begin
                    bsum[asg[i]] = msum[i];
                    nxt[asg[i]] = i;
                end
            moved = 1'b0;
            for (int c = 0; c < k; c++)
            begin
                if (nxt[c] != med[c])
                    moved = 1'b1;
                med[c] = nxt[c];
            end
            // a settled run repeats itself
            if (!moved)
                break;
        end
    endtask

    // work out the answer and advance the shadow state, in request order
    task automatic issue(input kmed_pkg::req_t r);
        kmed_pkg::rsp_t o;
        int p, dm;
        o = '0;
        p = r.point_index;
        dm = r.dim_index;
        case (r.func)
            kmed_pkg::FUNC_LOAD:
                if (p >= eff_n() || dm >= eff_d())
                    o.index_error = 1'b1;
                else
                begin
                    pts[p*NDIM+dm] = r.coord_in;
                    pts_set[p*NDIM+dm] = 1'b1;
                end
            kmed_pkg::FUNC_START:
            begin
                cluster_run();
                runs++;
            end
            kmed_pkg::FUNC_READ_ASG:
                if (p >= eff_n())
                    o.index_error = 1'b1;
                else
                    o.cluster_out = asg[p];
            default:
                if (p >= eff_k() || dm >= eff_d())
                    o.index_error = 1'b1;
                else if (med[p] < NPTS)
                    o.coord_out = pts[med[p]*NDIM+dm];
        endcase
        pending_reqs.push_back(r);
        due_rsps.push_back(o);
        items++;
    endtask

    function automatic bit start_ok();
        for (int p = 0; p < eff_n(); p++)
            for (int dm = 0; dm < eff_d(); dm++)
                if (!pts_set[p*NDIM+dm])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit med_read_ok(int c, int dm);
        if (c >= eff_k() || dm >= eff_d())
            return 1'b1;
        return med[c] >= NPTS || pts_set[med[c]*NDIM+dm];
    endfunction

    function automatic int run_cost();
        int n, d;
        n = eff_n();
        d = eff_d();
        return n_iter * (n * eff_k() * (d + 6) + n * (n - 1) / 2 * (d + 40) + 2 * n) + 100;
    endfunction

    function automatic logic [15:0] pick_coord();
        int base;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1:
            begin
                case ($urandom_range(2))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    default: return 16'h0000;
                endcase
            end
            default:
            begin
                // tight groups so that ties and real clusters show up
                case ($urandom_range(2))
                    0: base = -20000;
                    1: base = 0;
                    default: base = 15000;
                endcase
                return 16'(base + $urandom_range(8) - 4);
            end
        endcase
    endfunction

    function automatic kmed_pkg::req_t mk(logic [1:0] f, int p, int dm, logic [15:0] v);
        kmed_pkg::req_t r;
        r.func = f;
        r.point_index = p[9:0];
        r.dim_index = dm[2:0];
        r.coord_in = v;
        return r;
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || due_rsps.size() != 0 || req_valid)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[10:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            kmed_pkg::REG_POINTS:   n_pts = val & 11'h7FF;
            kmed_pkg::REG_DIMS:     n_dims = val & 4'hF;
            kmed_pkg::REG_CLUSTERS: n_clu = val & 5'h1F;
            default:                n_iter = val & 8'hFF;
        endcase
    endtask

    task automatic setup(input int np, input int nd, input int nk, input int ni);
        drain();
        cfg_write(kmed_pkg::REG_POINTS, np);
        cfg_write(kmed_pkg::REG_DIMS, nd);
        cfg_write(kmed_pkg::REG_CLUSTERS, nk);
        cfg_write(kmed_pkg::REG_ITERS, ni);
    endtask

    task automatic fill_phase(input int count);
        int made, left, f, p, dm;
        made = 0;
        left = RUN_BUDGET;
        while (made < count)
        begin
            if ($urandom_range(99) < 70 && run_cost() <= left)
            begin
                // whole data set, a run, then every answer
                for (int q = 0; q < eff_n(); q++)
                    for (int j = 0; j < eff_d(); j++)
                        issue(mk(kmed_pkg::FUNC_LOAD, q, j, pick_coord()));
                issue(mk(kmed_pkg::FUNC_START, $urandom_range(1023), $urandom_range(7),
                         16'($urandom)));
                left -= run_cost();
                for (int q = 0; q < eff_n(); q++)
                    issue(mk(kmed_pkg::FUNC_READ_ASG, q, $urandom_range(7), 16'($urandom)));
                for (int c = 0; c < eff_k(); c++)
                    for (int j = 0; j < eff_d(); j++)
                        issue(mk(kmed_pkg::FUNC_READ_MED, c, j, 16'($urandom)));
                made += eff_n() * (eff_d() + 1) + eff_k() * eff_d() + 1;
            end
            else
            begin
                f = $urandom_range(3);
                p = $urandom_range(1) ? $urandom_range(eff_n() - 1) : $urandom_range(1023);
                dm = $urandom_range(7);
                if (f == kmed_pkg::FUNC_START && !(start_ok() && run_cost() <= left))
                    f = kmed_pkg::FUNC_READ_ASG;
                if (f == kmed_pkg::FUNC_START)
                    left -= run_cost();
                if (f == kmed_pkg::FUNC_READ_MED && !med_read_ok(p, dm))
                    continue;
                issue(mk(f[1:0], p, dm, pick_coord()));
                made++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                req_valid <= 1'b1;
                req <= pending_reqs.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            hold_taken <= 0;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_taken != hold_asked)
        begin
            hold_cnt <= 400;
            hold_taken <= hold_asked;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        kmed_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cluster %0d coord %0d err %0b",
                             rsp.cluster_out, rsp.coord_out, rsp.index_error);
            end
            else
            begin
                want = due_rsps.pop_front();
                checked++;
                if (rsp.cluster_out !== want.cluster_out || rsp.coord_out !== want.coord_out
                    || rsp.index_error !== want.index_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected cluster %0d coord %0d err %0b, ",
                                  "got %0d %0d %0b"},
                                 checked, want.cluster_out, want.coord_out, want.index_error,
                                 rsp.cluster_out, rsp.coord_out, rsp.index_error);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_asked = 0;
        mismatches = 0;
        checked = 0;
        cycles = 0;
        items = 0;
        runs = 0;
        n_pts = kmed_pkg::RST_POINTS;
        n_dims = kmed_pkg::RST_DIMS;
        n_clu = kmed_pkg::RST_CLUSTERS;
        n_iter = kmed_pkg::RST_ITERS;
        for (int i = 0; i < NPTS * NDIM; i++)
        begin
            pts[i] = '0;
            pts_set[i] = 1'b0;
        end
        for (int i = 0; i < NPTS; i++)
            asg[i] = '0;
        for (int c = 0; c < NCLU; c++)
            med[c] = c;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: edge coordinates, far indices, bad indices
        issue(mk(kmed_pkg::FUNC_LOAD, 0, 0, 16'h8000));
        issue(mk(kmed_pkg::FUNC_LOAD, 0, 1, 16'h7FFF));
        issue(mk(kmed_pkg::FUNC_LOAD, 1, 0, 16'h0000));
        issue(mk(kmed_pkg::FUNC_LOAD, 1, 1, 16'hFFFF));
        issue(mk(kmed_pkg::FUNC_LOAD, 2, 0, 16'h0000));
        issue(mk(kmed_pkg::FUNC_LOAD, 2, 1, 16'h0000));
        issue(mk(kmed_pkg::FUNC_LOAD, 3, 0, 16'd100));
        issue(mk(kmed_pkg::FUNC_LOAD, 3, 1, -16'sd100));
        issue(mk(kmed_pkg::FUNC_LOAD, 1023, 1, 16'h5555));
        issue(mk(kmed_pkg::FUNC_LOAD, 5, 7, 16'hAAAA));
        issue(mk(kmed_pkg::FUNC_READ_ASG, 1023, 0, '0));
        issue(mk(kmed_pkg::FUNC_READ_MED, 3, 1, '0));
        issue(mk(kmed_pkg::FUNC_READ_MED, 0, 0, '0));
        issue(mk(kmed_pkg::FUNC_READ_MED, 15, 0, '0));
        issue(mk(kmed_pkg::FUNC_READ_MED, 0, 2, '0));
        // small set so a run is cheap
        setup(4, 2, 3, 3);
        issue(mk(kmed_pkg::FUNC_START, 1023, 7, 16'hFFFF));
        for (int p = 0; p < 4; p++)
            issue(mk(kmed_pkg::FUNC_READ_ASG, p, 0, '0));
        issue(mk(kmed_pkg::FUNC_READ_MED, 2, 1, '0));
        issue(mk(kmed_pkg::FUNC_READ_ASG, 1023, 0, '0));
        issue(mk(kmed_pkg::FUNC_READ_MED, 3, 0, '0));

        for (int m = 0; m < 3; m++)
        begin
            send_idle = (m == 0) ? 25 : (m == 1) ? 46 : 0;
            recv_idle = (m == 0) ? 46 : (m == 1) ? 25 : 0;
            for (int s = 0; s < 8; s++)
            begin
                case (s)
                    0: setup(8, 2, 3, 5);
                    1: setup(5, 8, 16, 4);
                    2: setup(12, 3, 4, 3);
                    3: setup(3, 1, 1, 255);
                    4: setup(6, 15, 0, 0);
                    5: setup(2047, 4, 31, 7);
                    6: setup(1, 3, 2, 2);
                    default: setup(10, 5, 6, 4);
                endcase
                fill_phase(55);
                // long result stall while requests keep coming
                if (m == 0 && s == 0)
                    hold_asked = 1;
            end
        end
        drain();

        $display("%0d requests, %0d clustering runs, %0d results checked over 26 size settings",
                 items, runs, checked);
        if (mismatches == 0 && due_rsps.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, due_rsps.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/kmed_pkg.sv
design/k_medoids_clustering.sv
tb/k_medoids_clustering_tb.sv
